// ===== rtl/core/ring_buffer_deque_defines.svh =====
// Assertion helpers for the checker file.
`ifndef RING_BUFFER_DEQUE_DEFINES_SVH
`define RING_BUFFER_DEQUE_DEFINES_SVH

// Clocked on clk_i, quiet while rst_ni is asserted.
`define RBD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked on clk_i, also checked during reset.
`define RBD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== rtl/core/rbd_pkg.sv =====
package rbd_pkg;

  localparam int unsigned DEPTH   = 1024;
  localparam int unsigned ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned COUNT_W = $clog2(DEPTH + 1);
  localparam int unsigned DATA_W  = 32;

  typedef enum logic [2:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_READ_FRONT = 3'd4,
    CMD_READ_BACK  = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_e;

  // Store access bundle from control to memory.
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [DATA_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  function automatic logic [ADDR_W-1:0] ptr_inc(input logic [ADDR_W-1:0] p);
    logic [ADDR_W-1:0] r;
    if (p == ADDR_W'(DEPTH - 1)) r = '0;
    else                         r = ADDR_W'(p + 1'b1);
    return r;
  endfunction

  function automatic logic [ADDR_W-1:0] ptr_dec(input logic [ADDR_W-1:0] p);
    logic [ADDR_W-1:0] r;
    if (p == '0) r = ADDR_W'(DEPTH - 1);
    else         r = ADDR_W'(p - 1'b1);
    return r;
  endfunction

endpackage

// ===== rtl/core/rbd_store.sv =====
module rbd_store (
  input  logic                             clk_i,
  input  rbd_pkg::mem_req_t                req_i,
  output logic [rbd_pkg::DATA_W-1:0]       rdata_o
);

  logic [rbd_pkg::DATA_W-1:0] mem [rbd_pkg::DEPTH];
  logic [rbd_pkg::DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    // read data holds until the next read
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/rbd_ctrl.sv =====
module rbd_ctrl (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [2:0]                        cmd_i,
  input  logic signed [31:0]                push_value_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [31:0]                out_value_o,
  output logic [1:0]                        status_o,
  output logic [rbd_pkg::COUNT_W-1:0]       count_now_o,
  output logic                              is_empty_o,
  output rbd_pkg::mem_req_t                 req_o,
  input  logic [rbd_pkg::DATA_W-1:0]        rdata_i
);

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } state_e;

  state_e                          state_q, state_d;
  logic [rbd_pkg::ADDR_W-1:0]      head_q, head_d;
  logic [rbd_pkg::ADDR_W-1:0]      tail_q, tail_d;
  logic [rbd_pkg::COUNT_W-1:0]     count_q, count_d;

  logic                            out_valid_q, out_valid_d;
  logic [rbd_pkg::DATA_W-1:0]      out_value_q, out_value_d;
  rbd_pkg::status_e                status_q, status_d;
  logic [rbd_pkg::COUNT_W-1:0]     out_count_q, out_count_d;
  logic                            out_empty_q, out_empty_d;

  logic                            out_free;
  logic                            in_fire;
  logic                            is_full;
  logic                            is_none;
  logic                            load_out;
  logic [rbd_pkg::COUNT_W-1:0]     cnt_res;
  rbd_pkg::status_e                st_res;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE) && out_free;
  assign in_fire    = in_valid_i && in_ready_o;
  assign is_full    = (count_q == rbd_pkg::COUNT_W'(rbd_pkg::DEPTH));
  assign is_none    = (count_q == '0);

  always_comb begin
    state_d  = state_q;
    head_d   = head_q;
    tail_d   = tail_q;
    count_d  = count_q;
    req_o    = '0;
    req_o.wdata = push_value_i;
    load_out = 1'b0;
    st_res   = rbd_pkg::STAT_OK;
    cnt_res  = count_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          load_out = 1'b1;
          unique case (cmd_i) inside
            rbd_pkg::CMD_PUSH_FRONT: begin
              if (is_full) begin
                st_res = rbd_pkg::STAT_FULL;
              end else begin
                head_d      = rbd_pkg::ptr_dec(head_q);
                req_o.we    = 1'b1;
                req_o.waddr = head_d;
                count_d     = rbd_pkg::COUNT_W'(count_q + 1'b1);
              end
            end
            rbd_pkg::CMD_PUSH_BACK: begin
              if (is_full) begin
                st_res = rbd_pkg::STAT_FULL;
              end else begin
                req_o.we    = 1'b1;
                req_o.waddr = tail_q;
                tail_d      = rbd_pkg::ptr_inc(tail_q);
                count_d     = rbd_pkg::COUNT_W'(count_q + 1'b1);
              end
            end
            rbd_pkg::CMD_POP_FRONT, rbd_pkg::CMD_READ_FRONT: begin
              if (is_none) begin
                st_res = rbd_pkg::STAT_EMPTY;
              end else begin
                req_o.re    = 1'b1;
                req_o.raddr = head_q;
                load_out    = 1'b0;
                state_d     = ST_READ;
                if (cmd_i == rbd_pkg::CMD_POP_FRONT) begin
                  head_d  = rbd_pkg::ptr_inc(head_q);
                  count_d = rbd_pkg::COUNT_W'(count_q - 1'b1);
                end
              end
            end
            rbd_pkg::CMD_POP_BACK, rbd_pkg::CMD_READ_BACK: begin
              if (is_none) begin
                st_res = rbd_pkg::STAT_EMPTY;
              end else begin
                req_o.re    = 1'b1;
                req_o.raddr = rbd_pkg::ptr_dec(tail_q);
                load_out    = 1'b0;
                state_d     = ST_READ;
                if (cmd_i == rbd_pkg::CMD_POP_BACK) begin
                  tail_d  = rbd_pkg::ptr_dec(tail_q);
                  count_d = rbd_pkg::COUNT_W'(count_q - 1'b1);
                end
              end
            end
            default: ;  // unused codes: no operation
          endcase
          cnt_res = count_d;
        end
      end
      ST_READ: begin
        // store data is valid now and holds until the next read
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_value_d = out_value_q;
    status_d    = status_q;
    out_count_d = out_count_q;
    out_empty_d = out_empty_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (load_out) begin
      out_valid_d = 1'b1;
      out_value_d = '0;
      status_d    = st_res;
      out_count_d = cnt_res;
      out_empty_d = (cnt_res == '0);
    end else if (state_q == ST_READ && out_free) begin
      out_valid_d = 1'b1;
      out_value_d = rdata_i;
      status_d    = rbd_pkg::STAT_OK;
      out_count_d = count_q;
      out_empty_d = (count_q == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      out_value_q <= '0;
      status_q    <= rbd_pkg::STAT_OK;
      out_count_q <= '0;
      out_empty_q <= 1'b1;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      out_value_q <= out_value_d;
      status_q    <= status_d;
      out_count_q <= out_count_d;
      out_empty_q <= out_empty_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_value_o = out_value_q;
  assign status_o    = status_q;
  assign count_now_o = out_count_q;
  assign is_empty_o  = out_empty_q;

endmodule

// ===== rtl/core/ring_buffer_deque.sv =====
// Result path: pushes, errors and no-ops load the result register straight from the
// accepted command; pops and reads first pass the registered read of the element store.
// Throughput: one command per cycle for pushes and errors while the result side is not
// stalled; pops and reads hold off the next command in the read state until loaded.
// Reset (rst_ni, async, active low) empties the deque and drops any pending result;
// the element store is not cleared, since only pushed entries are ever read.
module ring_buffer_deque (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // command channel
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [2:0]                    cmd_i,
  input  logic signed [31:0]            push_value_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [31:0]            out_value_o,
  output logic [1:0]                    status_o,
  output logic [10:0]                   count_now_o,
  output logic                          is_empty_o
);

  // Control: head/tail pointers, element count, result register.
  // Head points at the front element, tail one past the back; both wrap.
  rbd_pkg::mem_req_t                mem_req;
  logic [rbd_pkg::DATA_W-1:0]       mem_rdata;
  logic [rbd_pkg::COUNT_W-1:0]      count_now;

  rbd_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .cmd_i        (cmd_i),
    .push_value_i (push_value_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_value_o  (out_value_o),
    .status_o     (status_o),
    .count_now_o  (count_now),
    .is_empty_o   (is_empty_o),
    .req_o        (mem_req),
    .rdata_i      (mem_rdata)
  );

  // Element store: one write port for pushes, one registered read port for
  // pops and reads. Only one command is in flight, so no same-entry overlap.
  rbd_store u_store (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  assign count_now_o = 11'(count_now);

endmodule

// ===== rtl/core/rbd_checker.sv =====
`include "ring_buffer_deque_defines.svh"

module rbd_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               out_valid_o,
  input  logic               out_ready_i,
  input  logic signed [31:0] out_value_o,
  input  logic [1:0]         status_o,
  input  logic [10:0]        count_now_o,
  input  logic               is_empty_o
);

  logic res_err;
  assign res_err = out_valid_o && (status_o != rbd_pkg::STAT_OK);

  `RBD_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o, "result dropped")
  `RBD_ASSERT(a_empty_flag, out_valid_o |-> is_empty_o == (count_now_o == 11'd0), "bad empty flag")
  `RBD_ASSERT(a_count_max, out_valid_o |-> count_now_o <= 11'(rbd_pkg::DEPTH), "count above depth")
  `RBD_ASSERT(a_err_zero, res_err |-> out_value_o == 32'sd0, "error result carries data")
  `RBD_ASSERT_ALWAYS(a_rst_idle, !rst_ni |=> !out_valid_o, "result valid after reset")

endmodule

bind ring_buffer_deque rbd_checker u_rbd_checker (.*);

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

// Unused command codes: the block must answer with a no-op result.
localparam logic [2:0] CMD_UNUSED_LO = 3'd6;
localparam logic [2:0] CMD_UNUSED_HI = 3'd7;

typedef struct {
  logic [rbd_pkg::DATA_W-1:0]  word;
  rbd_pkg::status_e            status;
  logic [rbd_pkg::COUNT_W-1:0] count;
  logic                        empty;
} deque_result_t;

// Tracks the deque contents and the results still owed by the block.
class deque_tracker;
  logic [rbd_pkg::DATA_W-1:0]  store [rbd_pkg::DEPTH];
  logic [rbd_pkg::ADDR_W-1:0]  head;
  logic [rbd_pkg::ADDR_W-1:0]  tail;
  logic [rbd_pkg::COUNT_W-1:0] count;
  deque_result_t               pending_results [$];
  int unsigned                 fail_count;

  function new();
    head       = '0;
    tail       = '0;
    count      = '0;
    fail_count = 0;
  endfunction

  function logic [rbd_pkg::ADDR_W-1:0] step_fwd(input logic [rbd_pkg::ADDR_W-1:0] p);
    return (p == rbd_pkg::ADDR_W'(rbd_pkg::DEPTH - 1)) ? '0 : rbd_pkg::ADDR_W'(p + 1'b1);
  endfunction

  function logic [rbd_pkg::ADDR_W-1:0] step_back(input logic [rbd_pkg::ADDR_W-1:0] p);
    return (p == '0) ? rbd_pkg::ADDR_W'(rbd_pkg::DEPTH - 1) : rbd_pkg::ADDR_W'(p - 1'b1);
  endfunction

  // Apply one accepted command and queue the result it must produce.
  function void note_command(input logic [2:0] code,
                             input logic [rbd_pkg::DATA_W-1:0] word);
    deque_result_t r;
    r.word   = '0;
    r.status = rbd_pkg::STAT_OK;
    case (code)
      rbd_pkg::CMD_PUSH_FRONT: begin
        if (count == rbd_pkg::COUNT_W'(rbd_pkg::DEPTH)) begin
          r.status = rbd_pkg::STAT_FULL;
        end else begin
          head        = step_back(head);
          store[head] = word;
          count++;
        end
      end
      rbd_pkg::CMD_PUSH_BACK: begin
        if (count == rbd_pkg::COUNT_W'(rbd_pkg::DEPTH)) begin
          r.status = rbd_pkg::STAT_FULL;
        end else begin
          store[tail] = word;
          tail        = step_fwd(tail);
          count++;
        end
      end
      rbd_pkg::CMD_POP_FRONT: begin
        if (count == '0) begin
          r.status = rbd_pkg::STAT_EMPTY;
        end else begin
          r.word = store[head];
          head   = step_fwd(head);
          count--;
        end
      end
      rbd_pkg::CMD_POP_BACK: begin
        if (count == '0) begin
          r.status = rbd_pkg::STAT_EMPTY;
        end else begin
          tail   = step_back(tail);
          r.word = store[tail];
          count--;
        end
      end
      rbd_pkg::CMD_READ_FRONT: begin
        if (count == '0) r.status = rbd_pkg::STAT_EMPTY;
        else             r.word = store[head];
      end
      rbd_pkg::CMD_READ_BACK: begin
        if (count == '0) r.status = rbd_pkg::STAT_EMPTY;
        else             r.word = store[step_back(tail)];
      end
      default: ;
    endcase
    r.count = count;
    r.empty = (count == '0);
    pending_results.insert(pending_results.size(), r);
  endfunction

  function void check_result(input logic [rbd_pkg::DATA_W-1:0] word,
                             input logic [1:0] status,
                             input logic [rbd_pkg::COUNT_W-1:0] cnt, input logic empty);
    deque_result_t e;
    if (pending_results.size() == 0) begin
      $error("result transfer with nothing outstanding");
      fail_count++;
      return;
    end
    e = pending_results[0];
    pending_results.delete(0);
    if (word !== e.word) begin
      $error("out_value: expected %h, got %h", e.word, word);
      fail_count++;
    end
    if (status !== e.status) begin
      $error("status: expected %0d, got %0d", e.status, status);
      fail_count++;
    end
    if (cnt !== e.count) begin
      $error("count_now: expected %0d, got %0d", e.count, cnt);
      fail_count++;
    end
    if (empty !== e.empty) begin
      $error("is_empty: expected %0d, got %0d", e.empty, empty);
      fail_count++;
    end
  endfunction
endclass

module tb_top;

  localparam int CLK_PERIOD   = 10;
  localparam int RESET_CYCLES = 8;
  localparam int WARM_ITEMS   = 200;   // balanced mix, stays near empty
  localparam int STEADY_ITEMS = 400;   // no idling on either side for this stretch
  localparam int FULL_ITEMS   = 40;    // hover at full
  localparam int RANDOM_ITEMS = 1750;
  localparam int MIN_DRAIN    = 100;
  localparam int TAIL_CYCLES  = 8;     // idle time after the last result transfer
  localparam int STALL_LIMIT  = 2000;

  typedef enum {MIX_BALANCED, MIX_FILL, MIX_FULL, MIX_DRAIN} mix_e;

  logic                               clk_i        = 1'b0;
  logic                               rst_ni       = 1'b0;
  logic                               in_valid_i   = 1'b0;
  logic                               in_ready_o;
  logic [2:0]                         cmd_i        = 3'd0;
  logic signed [rbd_pkg::DATA_W-1:0]  push_value_i = '0;
  logic                               out_valid_o;
  logic                               out_ready_i  = 1'b0;
  logic signed [rbd_pkg::DATA_W-1:0]  out_value_o;
  logic [1:0]                         status_o;
  logic [rbd_pkg::COUNT_W-1:0]        count_now_o;
  logic                               is_empty_o;

  logic                               steady_flow  = 1'b0;
  int unsigned                        stall_cycles = 0;

  deque_tracker tracker = new();

  ring_buffer_deque u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .cmd_i       (cmd_i),
    .push_value_i(push_value_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_value_o (out_value_o),
    .status_o    (status_o),
    .count_now_o (count_now_o),
    .is_empty_o  (is_empty_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Result side: back-pressure about 16% of cycles, none during the steady stretch.
  always @(posedge clk_i) begin
    out_ready_i <= steady_flow || ($urandom_range(99) >= 16);
  end

  // Every result transfer is checked against the oldest outstanding prediction.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      tracker.check_result(out_value_o, status_o, count_now_o, is_empty_o);
  end

  // Count cycles with no transfer on either channel.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
  end

  initial begin
    while (stall_cycles < STALL_LIMIT) @(posedge clk_i);
    $display("Simulation FAILED");
    $finish;
  end

  // Present one command, with an optional leading gap, and hold it until transfer.
  task automatic send_cmd(input logic [2:0] code, input logic [rbd_pkg::DATA_W-1:0] word);
    while (!steady_flow && $urandom_range(99) < 16) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    cmd_i        <= code;
    push_value_i <= word;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    tracker.note_command(code, word);
  endtask

  function automatic logic [2:0] any_push();
    return $urandom_range(1) ? rbd_pkg::CMD_PUSH_BACK : rbd_pkg::CMD_PUSH_FRONT;
  endfunction

  function automatic logic [2:0] any_pop();
    return $urandom_range(1) ? rbd_pkg::CMD_POP_BACK : rbd_pkg::CMD_POP_FRONT;
  endfunction

  // Command mix per phase; the phases steer the fill level across its range.
  function automatic logic [2:0] pick_cmd(input mix_e mix);
    int unsigned r;
    r = $urandom_range(99);
    case (mix)
      MIX_BALANCED: begin
        if (r < 3) return $urandom_range(1) ? CMD_UNUSED_HI : CMD_UNUSED_LO;
        return 3'($urandom_range(5));
      end
      MIX_FILL: begin
        if (r < 90) return any_push();
        return 3'($urandom_range(7));
      end
      MIX_FULL: begin
        if (r < 50) return any_push();
        if (r < 70) return any_pop();
        return $urandom_range(1) ? rbd_pkg::CMD_READ_BACK : rbd_pkg::CMD_READ_FRONT;
      end
      default: begin
        if (r < 85) return any_pop();
        return 3'($urandom_range(5));
      end
    endcase
  endfunction

  initial begin
    int random_items;
    int fill_items;
    int drain_items;

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: every command on an empty deque, wrap of the head pointer below and
    // above zero, extreme data words, both unused codes, back to empty.
    send_cmd(rbd_pkg::CMD_POP_FRONT,  $urandom());
    send_cmd(rbd_pkg::CMD_POP_BACK,   $urandom());
    send_cmd(rbd_pkg::CMD_READ_FRONT, $urandom());
    send_cmd(rbd_pkg::CMD_READ_BACK,  $urandom());
    send_cmd(CMD_UNUSED_LO,           $urandom());
    send_cmd(CMD_UNUSED_HI,           $urandom());
    send_cmd(rbd_pkg::CMD_PUSH_FRONT, 32'h7FFF_FFFF);
    send_cmd(rbd_pkg::CMD_PUSH_BACK,  32'h8000_0000);
    send_cmd(rbd_pkg::CMD_READ_FRONT, $urandom());
    send_cmd(rbd_pkg::CMD_READ_BACK,  $urandom());
    send_cmd(rbd_pkg::CMD_PUSH_FRONT, 32'h0000_0000);
    send_cmd(rbd_pkg::CMD_PUSH_BACK,  32'hFFFF_FFFF);
    send_cmd(CMD_UNUSED_LO,           $urandom());
    send_cmd(rbd_pkg::CMD_POP_BACK,   $urandom());
    send_cmd(rbd_pkg::CMD_POP_FRONT,  $urandom());
    send_cmd(rbd_pkg::CMD_POP_FRONT,  $urandom());
    send_cmd(rbd_pkg::CMD_POP_BACK,   $urandom());
    send_cmd(rbd_pkg::CMD_PUSH_BACK,  32'h5555_5555);
    send_cmd(rbd_pkg::CMD_POP_FRONT,  $urandom());
    send_cmd(rbd_pkg::CMD_PUSH_FRONT, 32'hAAAA_AAAA);
    send_cmd(rbd_pkg::CMD_POP_BACK,   $urandom());

    random_items = 0;
    for (int i = 0; i < WARM_ITEMS; i++) begin
      send_cmd(pick_cmd(MIX_BALANCED), $urandom());
      random_items++;
    end

    // Fill to the top; the first part runs with no idling at all.
    steady_flow <= 1'b1;
    fill_items = 0;
    while (tracker.count < rbd_pkg::COUNT_W'(rbd_pkg::DEPTH)) begin
      if (fill_items == STEADY_ITEMS) steady_flow <= 1'b0;
      send_cmd(pick_cmd(MIX_FILL), $urandom());
      fill_items++;
      random_items++;
    end
    steady_flow <= 1'b0;

    // Pushes (refused when full), pops and reads around the full mark.
    for (int i = 0; i < FULL_ITEMS; i++) begin
      send_cmd(pick_cmd(MIX_FULL), $urandom());
      random_items++;
    end

    drain_items = 0;
    while ((random_items < RANDOM_ITEMS || drain_items < MIN_DRAIN) && tracker.count != '0)
    begin
      send_cmd(pick_cmd(MIX_DRAIN), $urandom());
      drain_items++;
      random_items++;
    end

    in_valid_i <= 1'b0;
    while (tracker.pending_results.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (tracker.fail_count == 0 && tracker.pending_results.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/rbd_pkg.sv
rtl/core/rbd_store.sv
rtl/core/rbd_ctrl.sv
rtl/core/ring_buffer_deque.sv
rtl/core/rbd_checker.sv
tb/tb_top.sv
